@@ sv/stq_pkg.sv @@
package stq_pkg;

   typedef logic [1:0]  kind_type;
   typedef logic [2:0]  status_type;
   typedef logic [31:0] tick_field_type;
   typedef logic [4:0]  slot_field_type;
   typedef logic [7:0]  tag_field_type;
   typedef logic [5:0]  occ_type;
   typedef logic [5:0]  pop_count_type;

   localparam kind_type KIND_CREATE = 2'd0;
   localparam kind_type KIND_REMOVE = 2'd1;
   localparam kind_type KIND_POLL   = 2'd2;

   localparam status_type STATUS_CREATED  = 3'd0;
   localparam status_type STATUS_FULL     = 3'd1;
   localparam status_type STATUS_REMOVED  = 3'd2;
   localparam status_type STATUS_EMPTY    = 3'd3;
   localparam status_type STATUS_MISMATCH = 3'd4;
   localparam status_type STATUS_NOTFOUND = 3'd5;
   localparam status_type STATUS_EXPIRED  = 3'd6;
   localparam status_type STATUS_NONE     = 3'd7;

   localparam pop_count_type MAX_POPS = 6'd32;

endpackage

@@ sv/stq_req_if.sv @@
interface stq_req_if import stq_pkg::*; ();
   logic           valid;
   logic           ready;
   kind_type       kind;
   tick_field_type deadline;
   slot_field_type slot_in;
   tag_field_type  tag_in;
   tick_field_type now;

   modport source (output valid, output kind, output deadline, output slot_in,
                   output tag_in, output now, input ready);
   modport sink   (input valid, input kind, input deadline, input slot_in,
                   input tag_in, input now, output ready);
endinterface

@@ sv/stq_rsp_if.sv @@
interface stq_rsp_if import stq_pkg::*; ();
   logic           valid;
   logic           ready;
   slot_field_type slot_out;
   status_type     status;
   tag_field_type  tag_out;
   occ_type        occupancy;
   logic           last;

   modport source (output valid, output slot_out, output status, output tag_out,
                   output occupancy, output last, input ready);
   modport sink   (input valid, input slot_out, input status, input tag_out,
                   input occupancy, input last, output ready);
endinterface

@@ sv/sorted_timeout_queue_core.sv @@
// Sorted timeout queue: a table of SLOTS timeout slots kept as a linked list
// ordered by absolute deadline, earliest first.
// req_chan carries one request: create (deadline, tag), remove (slot, tag)
// or poll (now). rsp_chan returns the results: one for create and remove,
// one per expired slot or a single none-expired result for poll, with last
// set on the final result of each request. Unused kind codes give no result.
// Requests are taken one at a time; req_chan.ready is high only while the
// sequencer is idle. All list work goes through a single-read-port deadline
// memory, next-pointer memory and tag memory and one shared comparator.
// Create scans for the lowest idle slot, then walks the list from the head
// to its place and links it in; remove checks the tag, finds the slot in
// the list and unlinks it; poll pops expired slots from the head in turn.
// A finished result sits in an output register; the next request is taken
// while it waits. When rsp_chan stalls, the sequencer holds at its next
// result until the register frees, and no state changes meanwhile.
// Synchronous reset marks every slot idle, clears all tags, empties the
// list and drops any pending result. No clearing pass is needed.
module sorted_timeout_queue_core import stq_pkg::*; #(
   parameter int SLOTS     = 32,
   parameter int TICK_BITS = 32,
   parameter int TAG_BITS  = 8
) (
   input  logic       clock,
   input  logic       reset,
   stq_req_if.sink    req_chan,
   stq_rsp_if.source  rsp_chan
);

   localparam int IDX_BITS = $clog2(SLOTS);
   localparam int PTR_BITS = IDX_BITS + 1;
   localparam int CNT_BITS = $clog2(SLOTS + 1);
   localparam logic [PTR_BITS-1:0] PTR_NIL = {1'b1, {IDX_BITS{1'b0}}};

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_C_SCAN   = 4'd1;
   localparam logic [3:0] ST_C_HCMP   = 4'd2;
   localparam logic [3:0] ST_C_NCMP   = 4'd3;
   localparam logic [3:0] ST_C_DCMP   = 4'd4;
   localparam logic [3:0] ST_C_LINK   = 4'd5;
   localparam logic [3:0] ST_R_TAG    = 4'd6;
   localparam logic [3:0] ST_R_CHK    = 4'd7;
   localparam logic [3:0] ST_R_HEAD   = 4'd8;
   localparam logic [3:0] ST_R_WALK   = 4'd9;
   localparam logic [3:0] ST_R_UNLINK = 4'd10;
   localparam logic [3:0] ST_P_RD     = 4'd11;
   localparam logic [3:0] ST_P_CMP    = 4'd12;

   logic [3:0]          state_ff, state_in;
   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [SLOTS-1:0]    busy_ff, busy_in;
   logic [SLOTS-1:0]    tagv_ff, tagv_in;
   logic [IDX_BITS-1:0] scan_ff, scan_in;
   logic [IDX_BITS-1:0] new_ff, new_in;
   logic [PTR_BITS-1:0] prev_ff, prev_in;
   logic [PTR_BITS-1:0] succ_ff, succ_in;
   pop_count_type       pops_ff, pops_in;
   logic [TAG_BITS-1:0] stored_ff, stored_in;

   logic [TICK_BITS-1:0] time_ff, time_in;
   slot_field_type      slot_ff, slot_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;

   logic                held_valid_ff, held_valid_in;
   logic [IDX_BITS-1:0] held_slot_ff, held_slot_in;
   logic [TAG_BITS-1:0] held_tag_ff, held_tag_in;
   occ_type             held_occ_ff, held_occ_in;

   logic                rsp_valid_ff;
   slot_field_type      rsp_slot_ff;
   status_type          rsp_status_ff;
   tag_field_type       rsp_tag_ff;
   occ_type             rsp_occ_ff;
   logic                rsp_last_ff;

   logic                 dl_we, dl_re;
   logic [IDX_BITS-1:0]  dl_waddr, dl_raddr;
   logic [TICK_BITS-1:0] dl_rd;
   logic                 nx_we, nx_re;
   logic [IDX_BITS-1:0]  nx_waddr, nx_raddr;
   logic [PTR_BITS-1:0]  nx_wdata, nx_rd;
   logic                 tg_we, tg_re;
   logic [IDX_BITS-1:0]  tg_waddr, tg_raddr;
   logic [TAG_BITS-1:0]  tg_rd;

   logic                 push, push_held, push_last;
   slot_field_type       push_slot;
   status_type           push_status;
   tag_field_type        push_tag;
   occ_type              push_occ;
   logic                 out_free, stall, accept;

   logic [TICK_BITS-1:0] cmp_a, cmp_b;
   logic                 cmp_lt;

   logic [IDX_BITS-1:0]  head_idx, rm_idx;
   logic [TAG_BITS-1:0]  tag_seen;
   logic                 head_nil, rm_range, expired;

   assign head_idx = head_ff[IDX_BITS-1:0];
   assign head_nil = head_ff[IDX_BITS];
   assign rm_idx   = IDX_BITS'(slot_ff);
   assign rm_range = 32'(slot_ff) < 32'(SLOTS);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign stall    = push && !out_free;
   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   stq_ram #(.WIDTH(TICK_BITS), .DEPTH(SLOTS)) u_deadline_ram (
      .clock   (clock),
      .wr_en   (dl_we && !stall),
      .wr_addr (dl_waddr),
      .wr_data (time_ff),
      .rd_en   (dl_re && !stall),
      .rd_addr (dl_raddr),
      .rd_data (dl_rd)
   );

   stq_ram #(.WIDTH(PTR_BITS), .DEPTH(SLOTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we && !stall),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_en   (nx_re && !stall),
      .rd_addr (nx_raddr),
      .rd_data (nx_rd)
   );

   stq_ram #(.WIDTH(TAG_BITS), .DEPTH(SLOTS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tg_we && !stall),
      .wr_addr (tg_waddr),
      .wr_data (tag_ff),
      .rd_en   (tg_re && !stall),
      .rd_addr (tg_raddr),
      .rd_data (tg_rd)
   );

   // shared comparator
   always_comb begin
      if (state_ff == ST_C_HCMP) begin
         cmp_a = time_ff;
         cmp_b = dl_rd;
      end else begin
         cmp_a = dl_rd;
         cmp_b = time_ff;
      end
      cmp_lt = cmp_a < cmp_b;
   end

   always_comb begin
      tag_seen = '0;
      case (state_ff)
         ST_R_CHK: tag_seen = tagv_ff[rm_idx]   ? tg_rd : '0;
         ST_P_CMP: tag_seen = tagv_ff[head_idx] ? tg_rd : '0;
         default:  tag_seen = '0;
      endcase
      expired = !head_nil && (pops_ff != MAX_POPS) && cmp_lt;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      busy_in       = busy_ff;
      tagv_in       = tagv_ff;
      scan_in       = scan_ff;
      new_in        = new_ff;
      prev_in       = prev_ff;
      succ_in       = succ_ff;
      pops_in       = pops_ff;
      stored_in     = stored_ff;
      time_in       = time_ff;
      slot_in       = slot_ff;
      tag_in        = tag_ff;
      held_valid_in = held_valid_ff;
      held_slot_in  = held_slot_ff;
      held_tag_in   = held_tag_ff;
      held_occ_in   = held_occ_ff;

      dl_we    = 1'b0;
      dl_waddr = scan_ff;
      dl_re    = 1'b0;
      dl_raddr = head_idx;
      nx_we    = 1'b0;
      nx_waddr = new_ff;
      nx_wdata = PTR_NIL;
      nx_re    = 1'b0;
      nx_raddr = head_idx;
      tg_we    = 1'b0;
      tg_waddr = scan_ff;
      tg_re    = 1'b0;
      tg_raddr = head_idx;

      push        = 1'b0;
      push_held   = 1'b0;
      push_last   = 1'b1;
      push_slot   = '0;
      push_status = STATUS_NONE;
      push_tag    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               slot_in = req_chan.slot_in;
               tag_in  = TAG_BITS'(req_chan.tag_in);
               if (req_chan.kind == KIND_POLL) begin
                  time_in = TICK_BITS'(req_chan.now);
               end else begin
                  time_in = TICK_BITS'(req_chan.deadline);
               end
               case (req_chan.kind)
                  KIND_CREATE: begin
                     scan_in  = '0;
                     state_in = ST_C_SCAN;
                  end
                  KIND_REMOVE: state_in = ST_R_TAG;
                  KIND_POLL: begin
                     pops_in       = '0;
                     held_valid_in = 1'b0;
                     state_in      = ST_P_RD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_C_SCAN: begin
            if (count_ff == CNT_BITS'(SLOTS)) begin
               push        = 1'b1;
               push_status = STATUS_FULL;
               state_in    = ST_IDLE;
            end else if (!busy_ff[scan_ff]) begin
               new_in           = scan_ff;
               busy_in[scan_ff] = 1'b1;
               tagv_in[scan_ff] = 1'b1;
               count_in         = count_ff + 1'b1;
               dl_we            = 1'b1;
               tg_we            = 1'b1;
               if (head_nil) begin
                  nx_we       = 1'b1;
                  nx_waddr    = scan_ff;
                  nx_wdata    = PTR_NIL;
                  head_in     = {1'b0, scan_ff};
                  push        = 1'b1;
                  push_slot   = 5'(scan_ff);
                  push_status = STATUS_CREATED;
                  push_tag    = 8'(tag_ff);
                  state_in    = ST_IDLE;
               end else begin
                  dl_re    = 1'b1;
                  dl_raddr = head_idx;
                  state_in = ST_C_HCMP;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_C_HCMP: begin
            if (cmp_lt) begin
               nx_we       = 1'b1;
               nx_waddr    = new_ff;
               nx_wdata    = head_ff;
               head_in     = {1'b0, new_ff};
               push        = 1'b1;
               push_slot   = 5'(new_ff);
               push_status = STATUS_CREATED;
               push_tag    = 8'(tag_ff);
               state_in    = ST_IDLE;
            end else begin
               prev_in  = head_ff;
               nx_re    = 1'b1;
               nx_raddr = head_idx;
               state_in = ST_C_NCMP;
            end
         end

         ST_C_NCMP: begin
            if (nx_rd[IDX_BITS]) begin
               nx_we    = 1'b1;
               nx_waddr = new_ff;
               nx_wdata = PTR_NIL;
               state_in = ST_C_LINK;
            end else begin
               succ_in  = nx_rd;
               dl_re    = 1'b1;
               dl_raddr = nx_rd[IDX_BITS-1:0];
               state_in = ST_C_DCMP;
            end
         end

         ST_C_DCMP: begin
            if (cmp_lt) begin
               prev_in  = succ_ff;
               nx_re    = 1'b1;
               nx_raddr = succ_ff[IDX_BITS-1:0];
               state_in = ST_C_NCMP;
            end else begin
               nx_we    = 1'b1;
               nx_waddr = new_ff;
               nx_wdata = succ_ff;
               state_in = ST_C_LINK;
            end
         end

         ST_C_LINK: begin
            nx_we       = 1'b1;
            nx_waddr    = prev_ff[IDX_BITS-1:0];
            nx_wdata    = {1'b0, new_ff};
            push        = 1'b1;
            push_slot   = 5'(new_ff);
            push_status = STATUS_CREATED;
            push_tag    = 8'(tag_ff);
            state_in    = ST_IDLE;
         end

         ST_R_TAG: begin
            if (!rm_range) begin
               push        = 1'b1;
               push_slot   = slot_ff;
               push_status = head_nil ? STATUS_EMPTY : STATUS_NOTFOUND;
               state_in    = ST_IDLE;
            end else begin
               tg_re    = 1'b1;
               tg_raddr = rm_idx;
               state_in = ST_R_CHK;
            end
         end

         ST_R_CHK: begin
            stored_in = tag_seen;
            push_slot = slot_ff;
            push_tag  = 8'(tag_seen);
            if (head_nil) begin
               push        = 1'b1;
               push_status = STATUS_EMPTY;
               state_in    = ST_IDLE;
            end else if (tag_seen != tag_ff) begin
               push        = 1'b1;
               push_status = STATUS_MISMATCH;
               state_in    = ST_IDLE;
            end else if (!busy_ff[rm_idx]) begin
               push        = 1'b1;
               push_status = STATUS_NOTFOUND;
               state_in    = ST_IDLE;
            end else if (head_idx == rm_idx) begin
               nx_re    = 1'b1;
               nx_raddr = rm_idx;
               state_in = ST_R_HEAD;
            end else begin
               prev_in  = head_ff;
               nx_re    = 1'b1;
               nx_raddr = head_idx;
               state_in = ST_R_WALK;
            end
         end

         ST_R_HEAD: begin
            head_in         = nx_rd;
            busy_in[rm_idx] = 1'b0;
            count_in        = count_ff - 1'b1;
            push            = 1'b1;
            push_slot       = slot_ff;
            push_status     = STATUS_REMOVED;
            push_tag        = 8'(stored_ff);
            state_in        = ST_IDLE;
         end

         ST_R_WALK: begin
            if (nx_rd[IDX_BITS]) begin
               push        = 1'b1;
               push_slot   = slot_ff;
               push_status = STATUS_NOTFOUND;
               push_tag    = 8'(stored_ff);
               state_in    = ST_IDLE;
            end else if (nx_rd == {1'b0, rm_idx}) begin
               nx_re    = 1'b1;
               nx_raddr = rm_idx;
               state_in = ST_R_UNLINK;
            end else begin
               prev_in  = nx_rd;
               nx_re    = 1'b1;
               nx_raddr = nx_rd[IDX_BITS-1:0];
            end
         end

         ST_R_UNLINK: begin
            nx_we           = 1'b1;
            nx_waddr        = prev_ff[IDX_BITS-1:0];
            nx_wdata        = nx_rd;
            busy_in[rm_idx] = 1'b0;
            count_in        = count_ff - 1'b1;
            push            = 1'b1;
            push_slot       = slot_ff;
            push_status     = STATUS_REMOVED;
            push_tag        = 8'(stored_ff);
            state_in        = ST_IDLE;
         end

         ST_P_RD: begin
            dl_re    = 1'b1;
            nx_re    = 1'b1;
            tg_re    = 1'b1;
            state_in = ST_P_CMP;
         end

         ST_P_CMP: begin
            push_slot   = 5'(held_slot_ff);
            push_status = STATUS_EXPIRED;
            push_tag    = 8'(held_tag_ff);
            push_held   = 1'b1;
            if (expired) begin
               push              = held_valid_ff;
               push_last         = 1'b0;
               head_in           = nx_rd;
               busy_in[head_idx] = 1'b0;
               count_in          = count_ff - 1'b1;
               pops_in           = pops_ff + 1'b1;
               held_valid_in     = 1'b1;
               held_slot_in      = head_idx;
               held_tag_in       = tag_seen;
               held_occ_in       = 6'(count_in);
               state_in          = ST_P_RD;
            end else begin
               push     = 1'b1;
               state_in = ST_IDLE;
               if (!held_valid_ff) begin
                  push_held   = 1'b0;
                  push_slot   = '0;
                  push_status = STATUS_NONE;
                  push_tag    = '0;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase

      push_occ = push_held ? held_occ_ff : 6'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= PTR_NIL;
         count_ff      <= '0;
         busy_ff       <= '0;
         tagv_ff       <= '0;
         held_valid_ff <= 1'b0;
      end else if (!stall) begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         tagv_ff       <= tagv_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         scan_ff      <= scan_in;
         new_ff       <= new_in;
         prev_ff      <= prev_in;
         succ_ff      <= succ_in;
         pops_ff      <= pops_in;
         stored_ff    <= stored_in;
         time_ff      <= time_in;
         slot_ff      <= slot_in;
         tag_ff       <= tag_in;
         held_slot_ff <= held_slot_in;
         held_tag_ff  <= held_tag_in;
         held_occ_ff  <= held_occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push && out_free) begin
         rsp_slot_ff   <= push_slot;
         rsp_status_ff <= push_status;
         rsp_tag_ff    <= push_tag;
         rsp_occ_ff    <= push_occ;
         rsp_last_ff   <= push_last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.slot_out  = rsp_slot_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.tag_out   = rsp_tag_ff;
   assign rsp_chan.occupancy = rsp_occ_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

@@ sv/stq_ram.sv @@
module stq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
